// ===== sv/xmr_pkg.sv =====
// Package for the XMODEM receiver: control codes, result record, CRC step.
// No dependencies; used by xmr_res_fifo, xmodem_receiver and tb_top.
package xmr_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned MaxRes    = 3;

  localparam logic [7:0] ByteSoh = 8'h01;
  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEot = 8'h04;
  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteNak = 8'h15;
  localparam logic [7:0] ByteCan = 8'h18;
  localparam logic [7:0] ByteC   = 8'h43;

  localparam logic [10:0] ShortLen = 11'd128;
  localparam logic [10:0] LongLen  = 11'd1024;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HDR   = 5'b00010,
    PH_CAN2  = 5'b00100,
    PH_PKT   = 5'b01000,
    PH_PURGE = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    PM_C    = 2'd0,
    PM_NAK  = 2'd1,
    PM_NONE = 2'd2
  } prompt_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_ACK_DONE   = 3'd1,
    ACT_ACK_CANCEL = 3'd2,
    ACT_NAK        = 3'd3,
    ACT_CAN_SYNC   = 3'd4,
    ACT_CAN_DUP    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    VERD_NONE    = 2'd0,
    VERD_COMMIT  = 2'd1,
    VERD_DISCARD = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_CANCEL   = 2'd1,
    ST_SYNC     = 2'd2,
    ST_DUP      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_SIZE     = 3'd0,
    REG_BYTE_TO  = 3'd1,
    REG_CAN_TO   = 3'd2,
    REG_QUIET    = 3'd3,
    REG_TRIES    = 3'd4,
    REG_DUP_LIM  = 3'd5
  } reg_e;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [23:0] data_offset;
    logic [1:0]  packet_verdict;
    logic        done_res;
    logic [1:0]  end_status;
    logic [23:0] received_total;
    logic        last;
  } res_t;

  // CRC-16 CCITT, poly 0x1021, one byte, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic res_t mk_res(input logic txv, input logic [7:0] txb, input logic dv,
                                  input logic [7:0] db, input logic [23:0] off,
                                  input logic [1:0] verd, input logic done,
                                  input logic [1:0] st, input logic [23:0] tot);
    res_t r;
    r.tx_valid       = txv;
    r.tx_byte        = txb;
    r.data_valid     = dv;
    r.data_byte      = db;
    r.data_offset    = off;
    r.packet_verdict = verd;
    r.done_res       = done;
    r.end_status     = st;
    r.received_total = tot;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/xmr_res_fifo.sv =====
// Result queue for the XMODEM receiver: takes up to three results a cycle,
// hands out one. Depends on xmr_pkg.
module xmr_res_fifo
  import xmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push_i [MaxRes],
  input  logic       pop_i,
  output logic       room_o,
  output logic       valid_o,
  output res_t       head_o
);

  res_t                 mem_q [FifoDepth];
  logic [FifoAw-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [FifoAw:0]      cnt_q, cnt_d;

  // three free slots needed for a worst-case transaction
  assign room_o  = (cnt_q <= (FifoAw + 1)'(FifoDepth - MaxRes));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + FifoAw'(push_n_i);
    rd_d  = pop_i ? rd_q + FifoAw'(1) : rd_q;
    cnt_d = cnt_q + (FifoAw + 1)'(push_n_i) - (FifoAw + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (i < int'(push_n_i)) begin
        mem_q[wr_q + FifoAw'(i)] <= push_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoAw + 1)'(FifoDepth)) else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("result queue underflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i != 2'd0 |-> $past(room_o) || cnt_q <= (FifoAw + 1)'(FifoDepth - MaxRes))
    else $error("push without room");
`endif

endmodule

// ===== sv/xmodem_receiver.sv =====
// XMODEM receiver top level: protocol state, APB register file, result queue.
// Depends on xmr_pkg and xmr_res_fifo.
//
// Receiving side of XMODEM (CRC-16 or checksum, 128/1024-byte packets). Each
// input transaction is a start command, one received serial byte or one time
// tick. The whole protocol step for a transaction is done in the cycle it is
// accepted, so a transaction can be taken every cycle; its 0 to 3 results
// land in a 4-entry result queue and leave one per cycle, the final one
// flagged by last. in_stall_o rises while the queue has fewer than three free
// entries, so with a stalled output the block holds off new input; with the
// output flowing, sustained throughput is one input per cycle as long as the
// average number of results per input stays at or below one. Payload bytes of
// a packet with the expected number and complement stream out tentatively at
// their file offset, clipped to requested_size, and a later commit or discard
// verdict settles them. Registers (APB, 32-bit, byte address 4*i):
// requested_size, byte_timeout_ticks, cancel_timeout_ticks, quiet_ticks,
// sync_tries, duplicate_limit. Write them only while the block is idle.
module xmodem_receiver
  import xmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] data_offset_o,
  output logic [1:0]  packet_verdict_o,
  output logic        done_res_o,
  output logic [1:0]  end_status_o,
  output logic [23:0] received_total_o,
  output logic        last_o,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [23:0] cfg_size_q;
  logic [15:0] cfg_byte_to_q, cfg_can_to_q, cfg_quiet_q;
  logic [7:0]  cfg_tries_q, cfg_dup_lim_q;

  // protocol state
  phase_e      phase_q, phase_d;
  prompt_e     prompt_q, prompt_d;
  action_e     pend_q, pend_d;
  logic [7:0]  try_q, try_d;
  logic        crc_mode_q, crc_mode_d;
  logic [7:0]  exp_num_q, exp_num_d;
  logic        long_q, long_d;
  logic [10:0] idx_q, idx_d;
  logic [7:0]  hnum_q, hnum_d, hcomp_q, hcomp_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] trail_q, trail_d;
  logic [23:0] total_q, total_d;
  logic [7:0]  dup_q, dup_d;
  logic [15:0] tick_q, tick_d;

  logic        in_acc, out_acc, cfg_wr;
  logic        fifo_room;
  res_t        res [MaxRes];
  logic [1:0]  res_n, push_n;
  res_t        head;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_stall_o = ~fifo_room;
  assign out_acc    = out_valid_o & ~out_stall_i;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign pready     = 1'b1;
  assign push_n     = in_acc ? res_n : 2'd0;

  // register file
  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_SIZE:    prdata = {8'h00, cfg_size_q};
      REG_BYTE_TO: prdata = {16'h0000, cfg_byte_to_q};
      REG_CAN_TO:  prdata = {16'h0000, cfg_can_to_q};
      REG_QUIET:   prdata = {16'h0000, cfg_quiet_q};
      REG_TRIES:   prdata = {24'h000000, cfg_tries_q};
      REG_DUP_LIM: prdata = {24'h000000, cfg_dup_lim_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q    <= '0;
      cfg_byte_to_q <= 16'd2000;
      cfg_can_to_q  <= 16'd1000;
      cfg_quiet_q   <= 16'd10;
      cfg_tries_q   <= 8'd16;
      cfg_dup_lim_q <= 8'd25;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[4:2]))
        REG_SIZE:    cfg_size_q    <= pwdata[23:0];
        REG_BYTE_TO: cfg_byte_to_q <= pwdata[15:0];
        REG_CAN_TO:  cfg_can_to_q  <= pwdata[15:0];
        REG_QUIET:   cfg_quiet_q   <= pwdata[15:0];
        REG_TRIES:   cfg_tries_q   <= pwdata[7:0];
        REG_DUP_LIM: cfg_dup_lim_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // one protocol step per accepted transaction
  always_comb begin
    logic        fail, comp_ok, is_new, is_dup, chk_ok, abort_now, cand;
    logic [8:0]  t;
    logic [10:0] plen;
    logic [11:0] nxt;
    logic [24:0] off;
    logic [23:0] room, take;
    logic [15:0] limit, tick_inc;
    logic [1:0]  verd;

    phase_d    = phase_q;   prompt_d = prompt_q;   pend_d  = pend_q;
    try_d      = try_q;     crc_mode_d = crc_mode_q; exp_num_d = exp_num_q;
    long_d     = long_q;    idx_d    = idx_q;      hnum_d  = hnum_q;
    hcomp_d    = hcomp_q;   crc_d    = crc_q;      sum_d   = sum_q;
    trail_d    = trail_q;   total_d  = total_q;    dup_d   = dup_q;
    tick_d     = tick_q;
    res_n      = 2'd0;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;
    fail = 1'b0; comp_ok = 1'b0; is_new = 1'b0; is_dup = 1'b0; chk_ok = 1'b0;
    abort_now = 1'b0; t = '0; nxt = '0; off = '0; room = '0; take = '0;
    verd = VERD_NONE;
    plen     = long_q ? LongLen : ShortLen;
    cand     = (idx_q >= 11'd2) && (hnum_q == exp_num_q) && (hcomp_q == ~hnum_q);
    limit    = (phase_q == PH_CAN2) ? cfg_can_to_q :
               (phase_q == PH_PURGE) ? cfg_quiet_q : cfg_byte_to_q;
    tick_inc = tick_q + 16'd1;

    case (kind_e'(kind_i))
      KIND_START: begin
        try_d = '0; prompt_d = PM_C; crc_mode_d = 1'b0; exp_num_d = 8'd1;
        total_d = '0; dup_d = cfg_dup_lim_q; pend_d = ACT_NONE; idx_d = '0;
        phase_d = PH_HDR; tick_d = '0;
        res[0] = mk_res(1'b1, ByteC, 1'b0, 8'h00, 24'h0, VERD_NONE, 1'b0,
                        ST_COMPLETE, total_d);
        res_n = 2'd1;
      end
      KIND_BYTE: begin
        case (phase_q)
          PH_HDR: begin
            if (rx_byte_i == ByteSoh || rx_byte_i == ByteStx) begin
              if (prompt_q == PM_C) crc_mode_d = 1'b1;
              prompt_d = PM_NONE; long_d = (rx_byte_i == ByteStx);
              idx_d = '0; hnum_d = '0; hcomp_d = '0; crc_d = '0; sum_d = '0;
              trail_d = '0; tick_d = '0; phase_d = PH_PKT;
            end else if (rx_byte_i == ByteEot) begin
              phase_d = PH_PURGE; pend_d = ACT_ACK_DONE; tick_d = '0;
            end else if (rx_byte_i == ByteCan) begin
              phase_d = PH_CAN2; tick_d = '0;
            end else begin
              fail = 1'b1;
            end
          end
          PH_CAN2: begin
            if (rx_byte_i == ByteCan) begin
              phase_d = PH_PURGE; pend_d = ACT_ACK_CANCEL; tick_d = '0;
            end else begin
              fail = 1'b1;
            end
          end
          PH_PKT: begin
            tick_d = '0;
            if (idx_q == 11'd0) begin
              hnum_d = rx_byte_i;
            end else if (idx_q == 11'd1) begin
              hcomp_d = rx_byte_i;
            end else if (idx_q < plen + 11'd2) begin
              crc_d = crc_step(crc_q, rx_byte_i);
              sum_d = sum_q + rx_byte_i;
              off   = {1'b0, total_q} + 25'(idx_q - 11'd2);
              if (cand && off < {1'b0, cfg_size_q}) begin
                res[0] = mk_res(1'b0, 8'h00, 1'b1, rx_byte_i, off[23:0], VERD_NONE,
                                1'b0, ST_COMPLETE, total_q);
                res_n = 2'd1;
              end
            end else begin
              trail_d = {trail_q[7:0], rx_byte_i};
            end
            idx_d = idx_q + 11'd1;
            nxt   = {1'b0, idx_q} + 12'd1;
            if (nxt >= {1'b0, plen} + 12'd3 + 12'(crc_mode_q)) begin
              // end of packet: judge it
              comp_ok = (hcomp_d == ~hnum_d);
              is_new  = (hnum_d == exp_num_q);
              is_dup  = (hnum_d == exp_num_q - 8'd1);
              chk_ok  = crc_mode_q ? (trail_d == crc_d) : (trail_d[7:0] == sum_d);
              try_d   = '0;
              if (comp_ok && (is_new || is_dup) && chk_ok) begin
                if (is_new) begin
                  if (total_q < cfg_size_q) begin
                    room    = cfg_size_q - total_q;
                    take    = (room > 24'(plen)) ? 24'(plen) : room;
                    total_d = total_q + take;
                  end
                  exp_num_d = exp_num_q + 8'd1;
                  dup_d     = cfg_dup_lim_q;
                  verd      = VERD_COMMIT;
                  abort_now = (cfg_dup_lim_q == 8'd0);
                end else if (dup_q <= 8'd1) begin
                  dup_d = '0; abort_now = 1'b1;
                end else begin
                  dup_d = dup_q - 8'd1;
                end
                if (abort_now) begin
                  if (verd != VERD_NONE) begin
                    res[0] = mk_res(1'b0, 8'h00, 1'b0, 8'h00, 24'h0, verd, 1'b0,
                                    ST_COMPLETE, total_d);
                    res_n = 2'd1;
                  end
                  phase_d = PH_PURGE; pend_d = ACT_CAN_DUP; tick_d = '0;
                end else begin
                  res[0] = mk_res(1'b1, ByteAck, 1'b0, 8'h00, 24'h0, verd, 1'b0,
                                  ST_COMPLETE, total_d);
                  res_n = 2'd1;
                  phase_d = PH_HDR; tick_d = '0;
                end
              end else begin
                if (comp_ok && is_new) begin
                  res[res_n] = mk_res(1'b0, 8'h00, 1'b0, 8'h00, 24'h0, VERD_DISCARD,
                                      1'b0, ST_COMPLETE, total_d);
                  res_n = res_n + 2'd1;
                end
                phase_d = PH_PURGE; pend_d = ACT_NAK; tick_d = '0;
              end
            end
          end
          PH_PURGE: tick_d = '0;
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          tick_d = tick_inc;
          if (tick_inc >= limit) begin
            case (phase_q)
              PH_PURGE: begin
                pend_d = ACT_NONE; phase_d = PH_IDLE; tick_d = '0;
                case (pend_q)
                  ACT_ACK_DONE, ACT_ACK_CANCEL: begin
                    res[0] = mk_res(1'b1, ByteAck, 1'b0, 8'h00, 24'h0, VERD_NONE, 1'b1,
                                    (pend_q == ACT_ACK_CANCEL) ? ST_CANCEL : ST_COMPLETE,
                                    total_q);
                    res_n = 2'd1;
                  end
                  ACT_NAK: begin
                    res[0] = mk_res(1'b1, ByteNak, 1'b0, 8'h00, 24'h0, VERD_NONE, 1'b0,
                                    ST_COMPLETE, total_q);
                    res_n = 2'd1;
                    try_d = '0; phase_d = PH_HDR;
                  end
                  ACT_CAN_SYNC, ACT_CAN_DUP: begin
                    res[0] = mk_res(1'b1, ByteCan, 1'b0, 8'h00, 24'h0, VERD_NONE, 1'b0,
                                    ST_COMPLETE, total_q);
                    res[1] = res[0];
                    res[2] = mk_res(1'b1, ByteCan, 1'b0, 8'h00, 24'h0, VERD_NONE, 1'b1,
                                    (pend_q == ACT_CAN_SYNC) ? ST_SYNC : ST_DUP, total_q);
                    res_n = 2'd3;
                  end
                  default: ;
                endcase
              end
              PH_PKT: begin
                if (cand) begin
                  res[0] = mk_res(1'b0, 8'h00, 1'b0, 8'h00, 24'h0, VERD_DISCARD, 1'b0,
                                  ST_COMPLETE, total_q);
                  res_n = 2'd1;
                end
                try_d = '0; phase_d = PH_PURGE; pend_d = ACT_NAK; tick_d = '0;
              end
              default: fail = 1'b1;
            endcase
          end
        end
      end
      default: ;
    endcase

    // failed header attempt: retry, fall back to NAK prompting, or give up
    if (fail) begin
      t = {1'b0, try_q} + 9'd1;
      if (t < {1'b0, cfg_tries_q} || prompt_q == PM_C) begin
        if (t < {1'b0, cfg_tries_q}) begin
          try_d = t[7:0];
        end else begin
          prompt_d = PM_NAK; try_d = '0;
        end
        phase_d = PH_HDR; tick_d = '0;
        if (prompt_d == PM_C || prompt_d == PM_NAK) begin
          res[0] = mk_res(1'b1, (prompt_d == PM_C) ? ByteC : ByteNak, 1'b0, 8'h00,
                          24'h0, VERD_NONE, 1'b0, ST_COMPLETE, total_q);
          res_n = 2'd1;
        end
      end else begin
        phase_d = PH_PURGE; pend_d = ACT_CAN_SYNC; tick_d = '0;
      end
    end

    if (res_n != 2'd0) res[res_n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;  prompt_q <= PM_C;  pend_q <= ACT_NONE;
      try_q <= '0;  crc_mode_q <= 1'b0;  exp_num_q <= 8'd1;  long_q <= 1'b0;
      idx_q <= '0;  hnum_q <= '0;  hcomp_q <= '0;  crc_q <= '0;  sum_q <= '0;
      trail_q <= '0;  total_q <= '0;  dup_q <= 8'd25;  tick_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;  prompt_q <= prompt_d;  pend_q <= pend_d;
      try_q <= try_d;  crc_mode_q <= crc_mode_d;  exp_num_q <= exp_num_d;
      long_q <= long_d;  idx_q <= idx_d;  hnum_q <= hnum_d;  hcomp_q <= hcomp_d;
      crc_q <= crc_d;  sum_q <= sum_d;  trail_q <= trail_d;  total_q <= total_d;
      dup_q <= dup_d;  tick_q <= tick_d;
    end
  end

  xmr_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push_i   (res),
    .pop_i    (out_acc),
    .room_o   (fifo_room),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign tx_valid_o       = head.tx_valid;
  assign tx_byte_o        = head.tx_byte;
  assign data_valid_o     = head.data_valid;
  assign data_byte_o      = head.data_byte;
  assign data_offset_o    = head.data_offset;
  assign packet_verdict_o = head.packet_verdict;
  assign done_res_o       = head.done_res;
  assign end_status_o     = head.end_status;
  assign received_total_o = head.received_total;
  assign last_o           = head.last;

`ifndef SYNTHESIS
  a_start_prompts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == KIND_START |=> out_valid_o) else $error("start gave no prompt");
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_n == 2'd3 |=> phase_q == PH_IDLE) else $error("abort did not idle");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 11'd1028) else $error("packet index overrun");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for xmodem_receiver, on which it depends with xmr_pkg:
// directed sequences, one full packet over the valid/stall channels, APB register setup.
module tb_top;
  import xmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;

  // Scoreboard: it carries its own model of the receiver and a queue of the
  // results that are still due. The model advances once per accepted
  // input transaction.
  class xmr_scoreboard;
    // register copies
    int unsigned req_size, byte_to, can_to, quiet, tries, dup_lim;
    // protocol state
    phase_e      ph;
    int unsigned try_cnt;
    prompt_e     pmode;
    bit          crc_on;
    logic [7:0]  exp_num;
    bit          long_pkt;
    int unsigned idx;
    logic [7:0]  hnum, hcomp;
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [15:0] trailer;
    int unsigned total;
    int unsigned dup_left;
    logic [15:0] ticks;
    action_e     act;

    res_t due[$];
    res_t step_res[$];
    int   errors;

    function new();
      req_size = 0; byte_to = 2000; can_to = 1000; quiet = 10; tries = 16; dup_lim = 25;
      ph = PH_IDLE; try_cnt = 0; pmode = PM_C; crc_on = 0; exp_num = 8'd1;
      long_pkt = 0; idx = 0; hnum = '0; hcomp = '0; crc = '0; sum = '0; trailer = '0;
      total = 0; dup_left = 25; ticks = '0; act = ACT_NONE; errors = 0;
    endfunction

    function void set_reg(reg_e r, int unsigned v);
      case (r)
        REG_SIZE:    req_size = v & 24'hFFFFFF;
        REG_BYTE_TO: byte_to  = v & 16'hFFFF;
        REG_CAN_TO:  can_to   = v & 16'hFFFF;
        REG_QUIET:   quiet    = v & 16'hFFFF;
        REG_TRIES:   tries    = v & 8'hFF;
        REG_DUP_LIM: dup_lim  = v & 8'hFF;
        default: ;
      endcase
    endfunction

    // bitwise CCITT update, MSB first
    function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ (16'(b) << 8);
      for (int i = 0; i < 8; i++) x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
      return x;
    endfunction

    function void put(bit txv, logic [7:0] txb, bit dv, logic [7:0] db, logic [23:0] off,
                      verdict_e v, bit dn, status_e st);
      res_t r;
      if (step_res.size() >= MaxRes) return;
      r.tx_valid = txv; r.tx_byte = txb; r.data_valid = dv; r.data_byte = db;
      r.data_offset = off; r.packet_verdict = v; r.done_res = dn; r.end_status = st;
      r.received_total = total[23:0]; r.last = 1'b0;
      step_res.push_back(r);
    endfunction

    function void send_tx(logic [7:0] b);
      put(1, b, 0, '0, '0, VERD_NONE, 0, ST_COMPLETE);
    endfunction

    function void verdict_only(verdict_e v);
      put(0, '0, 0, '0, '0, v, 0, ST_COMPLETE);
    endfunction

    function void enter_hdr();
      ph = PH_HDR; ticks = '0;
    endfunction

    function void start_purge(action_e a);
      ph = PH_PURGE; act = a; ticks = '0;
    endfunction

    function void prompt();
      if (pmode == PM_C) send_tx(ByteC);
      else if (pmode == PM_NAK) send_tx(ByteNak);
    endfunction

    // one header attempt lost: retry, fall back to NAK prompting, or give up
    function void attempt_failed();
      int unsigned t;
      t = try_cnt + 1;
      if (t < tries) begin
        try_cnt = t & 8'hFF; enter_hdr(); prompt();
      end else if (pmode == PM_C) begin
        pmode = PM_NAK; try_cnt = 0; enter_hdr(); prompt();
      end else begin
        start_purge(ACT_CAN_SYNC);
      end
    endfunction

    function void purge_done();
      action_e a;
      a = act; act = ACT_NONE; ph = PH_IDLE; ticks = '0;
      case (a)
        ACT_ACK_DONE:   put(1, ByteAck, 0, '0, '0, VERD_NONE, 1, ST_COMPLETE);
        ACT_ACK_CANCEL: put(1, ByteAck, 0, '0, '0, VERD_NONE, 1, ST_CANCEL);
        ACT_NAK: begin
          send_tx(ByteNak); try_cnt = 0; enter_hdr();
        end
        ACT_CAN_SYNC, ACT_CAN_DUP: begin
          send_tx(ByteCan); send_tx(ByteCan);
          put(1, ByteCan, 0, '0, '0, VERD_NONE, 1, (a == ACT_CAN_SYNC) ? ST_SYNC : ST_DUP);
        end
        default: ;
      endcase
    endfunction

    function bit candidate();
      return idx >= 2 && hnum == exp_num && hcomp == ~hnum;
    endfunction

    function void open_packet(bit lng);
      if (pmode == PM_C) crc_on = 1;
      pmode = PM_NONE; long_pkt = lng; idx = 0; hnum = '0; hcomp = '0;
      crc = '0; sum = '0; trailer = '0; ticks = '0; ph = PH_PKT;
    endfunction

    function void close_packet(int unsigned len);
      bit comp_ok, is_new, is_dup, chk_ok, abort_now;
      verdict_e v;
      int unsigned n;
      comp_ok = hcomp == ~hnum;
      is_new  = hnum == exp_num;
      is_dup  = hnum == exp_num - 8'd1;
      chk_ok  = crc_on ? (trailer == crc) : (trailer[7:0] == sum);
      try_cnt = 0;
      if (comp_ok && (is_new || is_dup) && chk_ok) begin
        v = VERD_NONE;
        if (is_new) begin
          if (total < req_size) begin
            n = req_size - total;
            if (n > len) n = len;
            total = (total + n) & 24'hFFFFFF;
          end
          exp_num++;
          dup_left = dup_lim;
          v = VERD_COMMIT;
          abort_now = dup_left == 0;
        end else if (dup_left <= 1) begin
          dup_left = 0; abort_now = 1;
        end else begin
          dup_left--; abort_now = 0;
        end
        if (abort_now) begin
          if (v != VERD_NONE) verdict_only(v);
          start_purge(ACT_CAN_DUP);
        end else begin
          put(1, ByteAck, 0, '0, '0, v, 0, ST_COMPLETE);
          enter_hdr();
        end
      end else begin
        if (comp_ok && is_new) verdict_only(VERD_DISCARD);
        start_purge(ACT_NAK);
      end
    endfunction

    function void packet_byte(logic [7:0] b);
      int unsigned len, i, off;
      len = long_pkt ? int'(LongLen) : int'(ShortLen);
      i = idx;
      ticks = '0;
      if (i == 0) hnum = b;
      else if (i == 1) hcomp = b;
      else if (i < len + 2) begin
        crc = crc16_byte(crc, b);
        sum = sum + b;
        off = total + (i - 2);
        if (candidate() && off < req_size)
          put(0, '0, 1, b, off[23:0], VERD_NONE, 0, ST_COMPLETE);
      end else begin
        trailer = {trailer[7:0], b};
      end
      idx = (i + 1) & 11'h7FF;
      if (i + 1 >= len + 3 + crc_on) close_packet(len);
    endfunction

    function void note_input(logic [1:0] k, logic [7:0] b);
      int unsigned limit;
      step_res.delete();
      if (k == KIND_START) begin
        try_cnt = 0; pmode = PM_C; crc_on = 0; exp_num = 8'd1; total = 0;
        dup_left = dup_lim; act = ACT_NONE; idx = 0;
        enter_hdr(); prompt();
      end else if (k == KIND_BYTE) begin
        case (ph)
          PH_HDR: begin
            if (b == ByteSoh) open_packet(0);
            else if (b == ByteStx) open_packet(1);
            else if (b == ByteEot) start_purge(ACT_ACK_DONE);
            else if (b == ByteCan) begin ph = PH_CAN2; ticks = '0; end
            else attempt_failed();
          end
          PH_CAN2: begin
            if (b == ByteCan) start_purge(ACT_ACK_CANCEL);
            else attempt_failed();
          end
          PH_PKT:   packet_byte(b);
          PH_PURGE: ticks = '0;
          default: ;
        endcase
      end else if (k == KIND_TICK && ph != PH_IDLE) begin
        limit = byte_to;
        if (ph == PH_CAN2) limit = can_to;
        else if (ph == PH_PURGE) limit = quiet;
        ticks++;
        if (ticks >= limit) begin
          if (ph == PH_PURGE) purge_done();
          else if (ph == PH_PKT) begin
            if (candidate()) verdict_only(VERD_DISCARD);
            try_cnt = 0;
            start_purge(ACT_NAK);
          end else attempt_failed();
        end
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      foreach (step_res[j]) due.push_back(step_res[j]);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %0h actual %0h", $realtime, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $realtime, got);
        errors++;
        return;
      end
      e = due.pop_front();
      cmp("tx_valid", 32'(e.tx_valid), 32'(got.tx_valid));
      cmp("tx_byte", 32'(e.tx_byte), 32'(got.tx_byte));
      cmp("data_valid", 32'(e.data_valid), 32'(got.data_valid));
      cmp("data_byte", 32'(e.data_byte), 32'(got.data_byte));
      cmp("data_offset", 32'(e.data_offset), 32'(got.data_offset));
      cmp("packet_verdict", 32'(e.packet_verdict), 32'(got.packet_verdict));
      cmp("done_res", 32'(e.done_res), 32'(got.done_res));
      cmp("end_status", 32'(e.end_status), 32'(got.end_status));
      cmp("received_total", 32'(e.received_total), 32'(got.received_total));
      cmp("last", 32'(e.last), 32'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_START;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  res_t        got;

  xmr_scoreboard sb = new();
  bit          no_idle = 1'b0;   // last part of the run: no gaps, no stalls
  bit          hold_req = 1'b0;  // asks the result side for one long hold-off
  int unsigned cycles = 0;

  xmodem_receiver uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .kind_i(kind), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .tx_valid_o(got.tx_valid), .tx_byte_o(got.tx_byte),
    .data_valid_o(got.data_valid), .data_byte_o(got.data_byte),
    .data_offset_o(got.data_offset), .packet_verdict_o(got.packet_verdict),
    .done_res_o(got.done_res), .end_status_o(got.end_status),
    .received_total_o(got.received_total), .last_o(got.last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: check every accepted result against the oldest
  // expectation, stall in random bursts, and serve a long hold-off on request.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall) sb.check_result(got);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 150;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One input transaction; waits for acceptance, then updates the model.
  task automatic send(input logic [1:0] k, input logic [7:0] b);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(k, b);
  endtask

  task automatic tick();
    send(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // sender pause: nothing more is offered until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input reg_e r, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(r) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic configure(input int unsigned sz, input int unsigned bto, input int unsigned cto,
                           input int unsigned qt, input int unsigned tr, input int unsigned dl);
    drain();
    apb_write(REG_SIZE, sz);
    apb_write(REG_BYTE_TO, bto);
    apb_write(REG_CAN_TO, cto);
    apb_write(REG_QUIET, qt);
    apb_write(REG_TRIES, tr);
    apb_write(REG_DUP_LIM, dl);
  endtask

  // ticks until the purge has finished; a stray byte now and then restarts it
  task automatic wait_quiet();
    int guard;
    guard = 0;
    while (sb.ph == PH_PURGE && guard < 2000) begin
      if ($urandom_range(0, 9) == 0) send(KIND_BYTE, 8'($urandom_range(0, 255)));
      else tick();
      guard++;
    end
  endtask

  // One packet. Number, complement, trailer can be spoiled; cut>0 stops
  // after that many bytes and lets the byte timeout expire.
  task automatic send_packet(input bit lng, input logic [7:0] num, input bit bad_comp,
                             input bit bad_chk, input int cut);
    logic [15:0] c;
    logic [7:0]  s, b;
    int unsigned len, guard;
    int sent;
    len = lng ? int'(LongLen) : int'(ShortLen);
    c = '0; s = '0; sent = 0;
    send(KIND_BYTE, lng ? ByteStx : ByteSoh);
    send(KIND_BYTE, num);
    send(KIND_BYTE, bad_comp ? ~num ^ (8'd1 << $urandom_range(0, 7)) : ~num);
    sent = 2;
    for (int i = 0; i < len; i++) begin
      if (cut > 0 && sent >= cut) break;
      b = 8'($urandom_range(0, 255));
      c = sb.crc16_byte(c, b);
      s = s + b;
      send(KIND_BYTE, b);
      sent++;
      if (sb.byte_to > 2 && $urandom_range(0, 63) == 0) tick();
    end
    if (cut > 0 && sent >= cut) begin
      guard = 0;
      while (sb.ph == PH_PKT && guard < 200) begin
        tick();
        guard++;
      end
      return;
    end
    if (bad_chk) begin
      c ^= 16'd1 << $urandom_range(0, 15);
      s ^= 8'd1 << $urandom_range(0, 7);
    end
    if (sb.crc_on) begin
      send(KIND_BYTE, c[15:8]);
      send(KIND_BYTE, c[7:0]);
    end else begin
      send(KIND_BYTE, s);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(300, 3, 2, 2, 1, 3);

    // Directed: idle-time inputs, prompt, bad header byte falls back to NAK,
    // CAN then other ends in a sync error, double CAN with a byte during the
    // purge, start while busy, EOT.
    send(KIND_TICK, 8'h00);
    send(KIND_BYTE, 8'hFF);
    send(2'd3, 8'hA5);
    send(KIND_START, 8'h00);
    send(KIND_BYTE, 8'h00);
    send(KIND_BYTE, ByteCan);
    send(KIND_BYTE, 8'h7F);
    send(2'd3, 8'h5A);
    wait_quiet();
    send(KIND_START, 8'h11);
    send(KIND_BYTE, ByteCan);
    send(KIND_BYTE, ByteCan);
    send(KIND_BYTE, 8'hAA);
    wait_quiet();
    send(KIND_START, 8'hFF);
    send(KIND_BYTE, ByteSoh);
    send(KIND_BYTE, 8'h01);
    send(KIND_START, 8'h55);
    send(KIND_BYTE, ByteEot);
    wait_quiet();

    // one good packet under a long hold-off on the result side
    hold_req = 1'b1;
    send(KIND_START, 8'h00);
    send_packet(0, sb.exp_num, 0, 0, 0);
    if (sb.ph == PH_HDR) send(KIND_BYTE, ByteEot);
    wait_quiet();
    drain();

    // last part: no gaps, no stalls; a packet cut short times out
    no_idle = 1'b1;
    send(KIND_START, 8'h00);
    send_packet(0, sb.exp_num, 0, 0, 6);
    wait_quiet();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
